// File: design/utf8ld_pkg.sv
// ----------------------------------------------------------------------------
// utf8ld_pkg
// Types, constants and helper functions shared by the lax UTF-8 decoder.
// ----------------------------------------------------------------------------
package utf8ld_pkg;

    localparam logic [7:0] LEAD2_MASK = 8'b0001_1111;
    localparam logic [7:0] LEAD3_MASK = 8'b0000_1111;
    localparam logic [7:0] LEAD4_MASK = 8'b0000_0111;
    localparam logic [7:0] CONT_MASK  = 8'b0011_1111;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_LW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [20:0] code_point;
        logic        code_valid;
        logic        last_of_text;
    } t_out_item;

    typedef struct packed {
        logic [1:0] count;
        t_out_item  res0;
        t_out_item  res1;
        logic       busy;
    } t_dec_out;

    function automatic logic [1:0] lead_needs(input logic [7:0] b);
        logic [1:0] n;
        if (b[7:6] != 2'b11) begin
            n = 2'd0;
        end else if (!b[5]) begin
            n = 2'd1;
        end else if (!b[4]) begin
            n = 2'd2;
        end else begin
            n = 2'd3;
        end
        return n;
    endfunction

    function automatic logic [20:0] compose(input logic [7:0] lead,
                                            input logic [7:0] c0,
                                            input logic [7:0] c1,
                                            input logic [7:0] c2,
                                            input logic [1:0] n);
        logic [7:0]  l1;
        logic [7:0]  l2;
        logic [7:0]  l3;
        logic [20:0] code;
        l1 = lead & LEAD2_MASK;
        l2 = lead & LEAD3_MASK;
        l3 = lead & LEAD4_MASK;
        case (n)
            2'd1:    code = {10'd0, l1[4:0], c0[5:0]};
            2'd2:    code = {5'd0, l2[3:0], c0[5:0], c1[5:0]};
            default: code = {l3[2:0], c0[5:0], c1[5:0], c2[5:0]};
        endcase
        return code;
    endfunction

endpackage

// File: design/utf8ld_decoder.sv
// ----------------------------------------------------------------------------
// utf8ld_decoder
// Sequence state and the single-pass decode of one byte into up to two results.
// ----------------------------------------------------------------------------
module utf8ld_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  utf8ld_pkg::t_in_item i_item,
    output utf8ld_pkg::t_dec_out o_dec
);

    logic [1:0] r_held_count;
    logic [1:0] r_needed;
    logic [7:0] r_held [3];

    logic [1:0] n_held_count;
    logic [1:0] n_needed;
    logic       n_store;
    logic [1:0] n_store_idx;

    logic [7:0] b;
    logic       eot;
    logic [1:0] ln_b;
    logic [1:0] ln_h1;
    utf8ld_pkg::t_dec_out dec;

    assign b     = i_item.text_byte;
    assign eot   = i_item.end_of_text;
    assign ln_b  = utf8ld_pkg::lead_needs(b);
    assign ln_h1 = utf8ld_pkg::lead_needs(r_held[1]);

    always_comb begin
        dec          = '0;
        dec.busy     = (r_held_count != 2'd0);
        n_held_count = r_held_count;
        n_needed     = r_needed;
        n_store      = 1'b0;
        n_store_idx  = r_held_count;
        if (r_held_count == 2'd0) begin
            if (ln_b == 2'd0) begin
                dec.count = 2'd1;
                dec.res0  = '{code_point: {13'd0, b}, code_valid: 1'b1, last_of_text: eot};
            end else if (eot) begin
                dec.count = 2'd1;
                dec.res0  = '{code_point: '0, code_valid: 1'b0, last_of_text: 1'b1};
            end else begin
                n_store      = 1'b1;
                n_store_idx  = 2'd0;
                n_held_count = 2'd1;
                n_needed     = ln_b;
            end
        end else if (r_needed <= 2'd1) begin
            dec.count = 2'd1;
            case (r_held_count)
                2'd1: dec.res0.code_point =
                    utf8ld_pkg::compose(r_held[0], b, 8'd0, 8'd0, 2'd1);
                2'd2: dec.res0.code_point =
                    utf8ld_pkg::compose(r_held[0], r_held[1], b, 8'd0, 2'd2);
                default: dec.res0.code_point =
                    utf8ld_pkg::compose(r_held[0], r_held[1], r_held[2], b, 2'd3);
            endcase
            dec.res0.code_valid   = 1'b1;
            dec.res0.last_of_text = eot;
            n_held_count          = 2'd0;
            n_needed              = 2'd0;
        end else if (!eot) begin
            n_store      = 1'b1;
            n_held_count = r_held_count + 2'd1;
            n_needed     = r_needed - 2'd1;
        end else begin
            // The string ends inside a sequence: the lead is dropped and the
            // remaining bytes are decoded again.
            n_held_count = 2'd0;
            n_needed     = 2'd0;
            dec.count    = 2'd1;
            if (r_held_count == 2'd2 && ln_h1 == 2'd0) begin
                dec.res0 = '{code_point: {13'd0, r_held[1]}, code_valid: 1'b1,
                             last_of_text: 1'b1};
                if (ln_b == 2'd0) begin
                    dec.res0.last_of_text = 1'b0;
                    dec.count = 2'd2;
                    dec.res1  = '{code_point: {13'd0, b}, code_valid: 1'b1,
                                  last_of_text: 1'b1};
                end
            end else if (r_held_count == 2'd2 && ln_h1 == 2'd1) begin
                dec.res0 = '{code_point: utf8ld_pkg::compose(r_held[1], b, 8'd0, 8'd0, 2'd1),
                             code_valid: 1'b1, last_of_text: 1'b1};
            end else if (ln_b == 2'd0) begin
                dec.res0 = '{code_point: {13'd0, b}, code_valid: 1'b1, last_of_text: 1'b1};
            end else begin
                dec.res0 = '{code_point: '0, code_valid: 1'b0, last_of_text: 1'b1};
            end
        end
    end

    assign o_dec = dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_needed     <= 2'd0;
        end else if (i_advance) begin
            r_held_count <= n_held_count;
            r_needed     <= n_needed;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && n_store && n_store_idx != 2'd3) begin
            r_held[n_store_idx] <= b;
        end
    end

endmodule

// File: design/utf8ld_out_fifo.sv
// ----------------------------------------------------------------------------
// utf8ld_out_fifo
// Small result queue that takes up to two results per cycle and gives one when not stalled.
// ----------------------------------------------------------------------------
module utf8ld_out_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [1:0]                      i_push_count,
    input  utf8ld_pkg::t_out_item           i_res0,
    input  utf8ld_pkg::t_out_item           i_res1,
    output logic                            o_valid,
    input  logic                            i_stall,
    output utf8ld_pkg::t_out_item           o_data,
    output logic [utf8ld_pkg::FIFO_LW-1:0]  o_level
);

    utf8ld_pkg::t_out_item r_mem [utf8ld_pkg::FIFO_DEPTH];

    logic [utf8ld_pkg::FIFO_AW-1:0] r_wptr;
    logic [utf8ld_pkg::FIFO_AW-1:0] r_rptr;
    logic [utf8ld_pkg::FIFO_LW-1:0] r_level;
    logic [utf8ld_pkg::FIFO_AW-1:0] wptr1;
    logic                           pop;

    assign wptr1   = r_wptr + 1'b1;
    assign pop     = o_valid && !i_stall;
    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rptr];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_level <= '0;
        end else begin
            r_wptr  <= r_wptr + i_push_count[utf8ld_pkg::FIFO_AW-1:0];
            r_rptr  <= r_rptr + {{(utf8ld_pkg::FIFO_AW-1){1'b0}}, pop};
            r_level <= r_level + {{(utf8ld_pkg::FIFO_LW-2){1'b0}}, i_push_count}
                       - {{(utf8ld_pkg::FIFO_LW-1){1'b0}}, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_wptr] <= i_res0;
        end
        if (i_push_count == 2'd2) begin
            r_mem[wptr1] <= i_res1;
        end
    end

endmodule

// File: design/utf8_lax_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_lax_decoder_unit
// Lax UTF-8 decoder: one text byte per transaction in, code points out.
// ----------------------------------------------------------------------------
// The input channel (i_valid, o_stall, i_data) carries one byte of a string
// with a flag on its final byte. The output channel (o_valid, i_stall,
// o_data) carries decoded code points, a flag for a real character and a
// flag on the final result of the string.
// An accepted byte is held in the input register, decoded in one pass and
// written into a four-entry result queue, from which the results are offered
// to the receiver. One byte is taken per cycle while the queue has room for
// two more results. A byte yields no, one or two results;
// two only when a string ends inside an incomplete sequence, and the queue
// absorbs that extra result while the decoder keeps running.
// Reset clears the sequence state, the input register's valid flag and the queue.
// When the receiver stalls, the queue fills and the input side stalls once
// fewer than two entries are free; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module utf8_lax_decoder_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  utf8ld_pkg::t_in_item  i_data,
    output logic                  o_valid,
    input  logic                  i_stall,
    output utf8ld_pkg::t_out_item o_data
);

    logic                           r_in_valid;
    utf8ld_pkg::t_in_item           r_in_item;
    logic                           advance;
    logic                           accept;
    logic [utf8ld_pkg::FIFO_LW-1:0] level;
    utf8ld_pkg::t_dec_out           dec;
    logic [1:0]                     push_count;

    assign advance    = r_in_valid && (level <= utf8ld_pkg::FIFO_LW'(utf8ld_pkg::FIFO_DEPTH - 2));
    assign o_stall    = r_in_valid && !advance;
    assign accept     = i_valid && !o_stall;
    assign push_count = advance ? dec.count : 2'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_item <= i_data;
        end
    end

    utf8ld_decoder u_decoder (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_dec     (dec)
    );

    utf8ld_out_fifo u_out_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (push_count),
        .i_res0       (dec.res0),
        .i_res1       (dec.res1),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data),
        .o_level      (level)
    );

`ifndef SYNTH
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= utf8ld_pkg::FIFO_LW'(utf8ld_pkg::FIFO_DEPTH))
        else $error("result queue level exceeds its depth");

    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_item.end_of_text |-> dec.count != 2'd0)
        else $error("final byte of a string produced no result");

    a_end_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_item.end_of_text |=> !dec.busy)
        else $error("sequence state not cleared at the end of a string");

    a_pair_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && dec.count == 2'd2 |-> r_in_item.end_of_text && dec.res1.last_of_text)
        else $error("two results produced outside an end-of-string replay");
`endif

endmodule

// File: sim/utf8_lax_decoder_unit_tb.sv
// ----------------------------------------------------------------------------
// utf8_lax_decoder_unit_tb
// Self-checking testbench for the lax UTF-8 decoder unit.
// ----------------------------------------------------------------------------
// A short table of directed bytes covers the sequence lengths, the extreme
// code points and the cases where a string ends early. Random strings follow,
// most of them well formed with random content and some cut short, mixed
// with bursts of arbitrary bytes. Every accepted byte is run through a
// behavioural decoder kept in the testbench. Each result transaction is
// checked field by field against the oldest outstanding code point. The run
// has three phases of handshake pressure: a mostly stalling receiver, then a
// mostly idle sender, then neither.
// ----------------------------------------------------------------------------
module utf8_lax_decoder_unit_tb;

    typedef struct packed {
        logic [7:0]            text_b;
        logic                  eot;
        logic                  typed;
        logic [1:0]            n_res;
        utf8ld_pkg::t_out_item r0;
        utf8ld_pkg::t_out_item r1;
    } t_stim_row;

    localparam logic                  ROW_TYPED        = 1'b1;
    localparam logic                  ROW_PREDICTED    = 1'b0;
    localparam utf8ld_pkg::t_out_item NO_CODE          = '0;
    localparam int                    N_DIRECTED       = 25;
    localparam int                    RANDOM_PER_PHASE = 517;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    utf8ld_pkg::t_in_item  i_data;
    logic                  o_valid;
    logic                  i_stall;
    utf8ld_pkg::t_out_item o_data;

    t_stim_row             byte_q [$];
    utf8ld_pkg::t_out_item code_q [$];
    t_stim_row             cur_row;

    logic [7:0] pend_bytes [3];
    int         pend_cnt;
    int         miss_cnt;

    int send_idle_pct;
    int recv_stall_pct;
    int err_cnt;
    int bytes_sent;
    int strings_sent;
    int codes_checked;
    int bare_markers;
    int double_results;

    t_stim_row dir_tab [N_DIRECTED] = '{
        {8'h00, 1'b0, ROW_TYPED, 2'd1, {21'h000000, 1'b1, 1'b0}, NO_CODE},
        {8'h7F, 1'b1, ROW_TYPED, 2'd1, {21'h00007F, 1'b1, 1'b1}, NO_CODE},
        {8'h80, 1'b0, ROW_TYPED, 2'd1, {21'h000080, 1'b1, 1'b0}, NO_CODE},
        {8'hC3, 1'b0, ROW_TYPED, 2'd0, NO_CODE, NO_CODE},
        {8'hA9, 1'b0, ROW_TYPED, 2'd1, {21'h0000E9, 1'b1, 1'b0}, NO_CODE},
        {8'hE2, 1'b0, ROW_TYPED, 2'd0, NO_CODE, NO_CODE},
        {8'h82, 1'b0, ROW_TYPED, 2'd0, NO_CODE, NO_CODE},
        {8'hAC, 1'b1, ROW_TYPED, 2'd1, {21'h0020AC, 1'b1, 1'b1}, NO_CODE},
        {8'hFF, 1'b0, ROW_TYPED, 2'd0, NO_CODE, NO_CODE},
        {8'hFF, 1'b0, ROW_TYPED, 2'd0, NO_CODE, NO_CODE},
        {8'hFF, 1'b0, ROW_TYPED, 2'd0, NO_CODE, NO_CODE},
        {8'hFF, 1'b0, ROW_TYPED, 2'd1, {21'h1FFFFF, 1'b1, 1'b0}, NO_CODE},
        {8'hC0, 1'b1, ROW_TYPED, 2'd1, {21'h000000, 1'b0, 1'b1}, NO_CODE},
        {8'hE0, 1'b0, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'h41, 1'b1, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'hF0, 1'b0, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'hC2, 1'b0, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'hE0, 1'b1, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'hF0, 1'b0, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'h41, 1'b0, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'h42, 1'b1, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'hF0, 1'b0, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'hE5, 1'b1, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'hDF, 1'b0, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE},
        {8'h7F, 1'b1, ROW_PREDICTED, 2'd0, NO_CODE, NO_CODE}
    };

    utf8_lax_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic int cont_needed(input logic [7:0] b);
        if (b[7:6] != 2'b11) begin
            return 0;
        end
        if (!b[5]) begin
            return 1;
        end
        if (!b[4]) begin
            return 2;
        end
        return 3;
    endfunction

    function automatic logic [20:0] join_code(input logic [7:0] lead,
                                              input logic [2:0][7:0] conts,
                                              input int n);
        logic [20:0] code;
        int          i;
        code = '0;
        if (n == 1) begin
            code[7:0] = lead & utf8ld_pkg::LEAD2_MASK;
        end else if (n == 2) begin
            code[7:0] = lead & utf8ld_pkg::LEAD3_MASK;
        end else begin
            code[7:0] = lead & utf8ld_pkg::LEAD4_MASK;
        end
        for (i = 0; i < n; i++) begin
            code = (code << 6) | {15'd0, conts[i][5:0]};
        end
        return code;
    endfunction

    // Advances the decoder state by one byte and returns the code points it
    // releases, at most two.
    function automatic int decode_byte(input logic [7:0] b, input logic eot,
                                       output utf8ld_pkg::t_out_item r0,
                                       output utf8ld_pkg::t_out_item r1);
        utf8ld_pkg::t_out_item res [2];
        logic [2:0][7:0]       cbuf;
        logic [7:0]            rbuf [3];
        int                    n;
        int                    len;
        int                    p;
        int                    cnt;
        int                    i;
        cnt = 0;
        res[0] = NO_CODE;
        res[1] = NO_CODE;
        cbuf = '0;
        if (pend_cnt == 0) begin
            n = cont_needed(b);
            if (n == 0) begin
                res[0] = {13'd0, b, 1'b1, eot};
                cnt = 1;
            end else if (eot) begin
                res[0] = {21'd0, 1'b0, 1'b1};
                cnt = 1;
            end else begin
                pend_bytes[0] = b;
                pend_cnt = 1;
                miss_cnt = n;
            end
        end else if (miss_cnt <= 1) begin
            n = (pend_cnt > 3) ? 3 : pend_cnt;
            for (i = 1; i < n; i++) begin
                cbuf[i - 1] = pend_bytes[i];
            end
            cbuf[n - 1] = b;
            res[0] = {join_code(pend_bytes[0], cbuf, n), 1'b1, eot};
            cnt = 1;
            pend_cnt = 0;
            miss_cnt = 0;
        end else if (!eot) begin
            pend_bytes[pend_cnt] = b;
            pend_cnt++;
            miss_cnt--;
        end else begin
            // The string ended inside a sequence: the lead byte is dropped and
            // whatever followed it is decoded again on its own.
            len = 0;
            for (i = 1; i < pend_cnt; i++) begin
                rbuf[len] = pend_bytes[i];
                len++;
            end
            rbuf[len] = b;
            len++;
            p = 0;
            while (p < len && cnt < 2) begin
                n = cont_needed(rbuf[p]);
                if (n == 0) begin
                    res[cnt] = {13'd0, rbuf[p], 1'b1, (p + 1 >= len)};
                    cnt++;
                    p++;
                end else if (p + n >= len) begin
                    p++;
                end else begin
                    cbuf = '0;
                    for (i = 0; i < n; i++) begin
                        cbuf[i] = rbuf[p + 1 + i];
                    end
                    res[cnt] = {join_code(rbuf[p], cbuf, n), 1'b1, (p + n + 1 >= len)};
                    cnt++;
                    p += n + 1;
                end
            end
            if (cnt == 0) begin
                res[0] = {21'd0, 1'b0, 1'b1};
                cnt = 1;
            end else begin
                res[cnt - 1].last_of_text = 1'b1;
            end
            pend_cnt = 0;
            miss_cnt = 0;
        end
        r0 = res[0];
        r1 = res[1];
        return cnt;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        err_cnt++;
    endtask

    // Mostly well-formed strings with random content, some cut short inside
    // their last sequence, and now and then a burst of arbitrary bytes.
    task automatic queue_random_text(input int n_items);
        logic [7:0]  str [$];
        logic [31:0] rnd;
        t_stim_row   row;
        int          queued;
        int          n_chars;
        int          seq_n;
        int          c;
        int          i;
        queued = 0;
        row = '0;
        while (queued < n_items) begin
            str.delete();
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    rnd = $urandom;
                    row.text_b = rnd[7:0];
                    row.eot = ($urandom_range(3) == 0);
                    byte_q.push_back(row);
                    queued++;
                end
            end else begin
                n_chars = $urandom_range(1, 6);
                seq_n = 0;
                for (c = 0; c < n_chars; c++) begin
                    rnd = $urandom;
                    case ($urandom_range(9))
                        0, 1, 2: begin
                            rnd[7] = 1'b0;
                            seq_n = 0;
                        end
                        3: begin
                            rnd[7:6] = 2'b10;
                            seq_n = 0;
                        end
                        4, 5: begin
                            rnd[7:5] = 3'b110;
                            seq_n = 1;
                        end
                        6, 7: begin
                            rnd[7:4] = 4'b1110;
                            seq_n = 2;
                        end
                        default: begin
                            rnd[7:4] = 4'b1111;
                            seq_n = 3;
                        end
                    endcase
                    str.push_back(rnd[7:0]);
                    repeat (seq_n) begin
                        rnd = $urandom;
                        if ($urandom_range(7) != 0) begin
                            rnd[7:6] = 2'b10;
                        end
                        str.push_back(rnd[7:0]);
                    end
                end
                if (seq_n > 0 && $urandom_range(3) == 0) begin
                    repeat ($urandom_range(1, seq_n)) void'(str.pop_back());
                end
                for (i = 0; i < str.size(); i++) begin
                    row.text_b = str[i];
                    row.eot = (i == str.size() - 1);
                    byte_q.push_back(row);
                end
                queued += str.size();
                strings_sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin : drive_proc
        utf8ld_pkg::t_out_item p0;
        utf8ld_pkg::t_out_item p1;
        int                    n;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                n = decode_byte(cur_row.text_b, cur_row.eot, p0, p1);
                if (cur_row.typed) begin
                    n = int'(cur_row.n_res);
                    p0 = cur_row.r0;
                    p1 = cur_row.r1;
                end
                if (n > 0) begin
                    code_q.push_back(p0);
                end
                if (n > 1) begin
                    code_q.push_back(p1);
                    double_results++;
                end
                bytes_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_row = byte_q.pop_front();
                    i_valid <= 1'b1;
                    i_data <= {cur_row.text_b, cur_row.eot};
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        utf8ld_pkg::t_out_item want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (code_q.size() == 0) begin
                    report_mismatch("result with nothing outstanding", 32'(o_data), 32'd0);
                end else begin
                    want = code_q.pop_front();
                    if (o_data.code_point !== want.code_point) begin
                        report_mismatch("code_point", 32'(o_data.code_point),
                                        32'(want.code_point));
                    end
                    if (o_data.code_valid !== want.code_valid) begin
                        report_mismatch("code_valid", 32'(o_data.code_valid),
                                        32'(want.code_valid));
                    end
                    if (o_data.last_of_text !== want.last_of_text) begin
                        report_mismatch("last_of_text", 32'(o_data.last_of_text),
                                        32'(want.last_of_text));
                    end
                    if (!want.code_valid) begin
                        bare_markers++;
                    end
                    codes_checked++;
                end
            end
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    initial begin : main_proc
        int ph;
        int k;
        int wait_cnt;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_data = '0;
        cur_row = '0;
        pend_cnt = 0;
        miss_cnt = 0;
        err_cnt = 0;
        bytes_sent = 0;
        strings_sent = 0;
        codes_checked = 0;
        bare_markers = 0;
        double_results = 0;
        send_idle_pct = 15;
        recv_stall_pct = 59;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (ph = 0; ph < 3; ph++) begin
            @(negedge i_clk);
            send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 59 : 0;
            recv_stall_pct = (ph == 0) ? 59 : (ph == 1) ? 15 : 0;
            if (ph == 0) begin
                for (k = 0; k < N_DIRECTED; k++) begin
                    byte_q.push_back(dir_tab[k]);
                end
            end
            queue_random_text(RANDOM_PER_PHASE);
            while (byte_q.size() != 0 || i_valid) begin
                @(negedge i_clk);
            end
        end
        wait_cnt = 0;
        while (code_q.size() != 0 && wait_cnt < 5000) begin
            @(negedge i_clk);
            wait_cnt++;
        end
        repeat (8) @(negedge i_clk);
        if (code_q.size() != 0) begin
            $display("%0d expected code points were never delivered", code_q.size());
            err_cnt++;
        end
        $display("Decoded %0d bytes in %0d random strings plus directed cases and noise.",
                 bytes_sent, strings_sent);
        $display("Checked %0d code points, %0d bare end markers, %0d double replays.",
                 codes_checked, bare_markers, double_results);
        if (err_cnt == 0) begin
            $display("utf8_lax_decoder_unit_tb: PASS");
        end else begin
            $display("utf8_lax_decoder_unit_tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog_proc
        #8000000;
        $display("Run did not finish in time.");
        $display("utf8_lax_decoder_unit_tb: FAIL");
        $finish;
    end

endmodule

// File: sim.f
design/utf8ld_pkg.sv
design/utf8ld_decoder.sv
design/utf8ld_out_fifo.sv
design/utf8_lax_decoder_unit.sv
sim/utf8_lax_decoder_unit_tb.sv
